[design/clni_pkg.sv]
// ----------------------------------------------------------------------------
// clni_pkg: shared types and constants for the character LCD nibble interface
// Request codes, sequencer phases, init steps, register map and pin constants.
// ----------------------------------------------------------------------------
package clni_pkg;

   // payload widths
   localparam int REQ_TYPE_W  = 3;
   localparam int BYTE_W      = 8;
   localparam int LINE_W      = 3;
   localparam int COLUMN_W    = 6;
   localparam int NIBBLE_W    = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int TICK_W      = 16;
   localparam int MS_W        = 8;
   localparam int SETTLE_W    = 10;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_TICK   = 3'd0,
      REQ_CMD    = 3'd1,
      REQ_CHAR   = 3'd2,
      REQ_CURSOR = 3'd3,
      REQ_CLEAR  = 3'd4,
      REQ_INIT   = 3'd5
   } req_code_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_HI_EN   = 4'd1,
      PH_GAP     = 4'd2,
      PH_LO_EN   = 4'd3,
      PH_SETTLE  = 4'd4,
      PH_STROBE  = 4'd5,
      PH_US_WAIT = 4'd6,
      PH_WD_HI   = 4'd7,
      PH_WD_LO   = 4'd8
   } phase_type;

   typedef enum logic [3:0] {
      STEP_NONE       = 4'd0,
      STEP_POWER_WAIT = 4'd1,
      STEP_WAKE_1     = 4'd2,
      STEP_WAIT_5MS_1 = 4'd3,
      STEP_WAKE_2     = 4'd4,
      STEP_WAIT_100US = 4'd5,
      STEP_WAKE_3     = 4'd6,
      STEP_WAIT_5MS_2 = 4'd7,
      STEP_SET_4BIT   = 4'd8,
      STEP_WAIT_40US  = 4'd9,
      STEP_FUNC_SET   = 4'd10,
      STEP_DISP_OFF   = 4'd11,
      STEP_DISP_ON    = 4'd12,
      STEP_ENTRY_MODE = 4'd13,
      STEP_CLEAR_TAIL = 4'd14
   } init_step_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TWO_LINE   = 3'd0,
      CSR_WIDE_ROWS  = 3'd1,
      CSR_PULSE      = 3'd2,
      CSR_SETTLE     = 3'd3,
      CSR_TICK_MS    = 3'd4,
      CSR_CLEAR_MS   = 3'd5,
      CSR_POWER_MS   = 3'd6
   } csr_index_type;

   // row base addresses
   localparam logic [BYTE_W-1:0] BASE_LINE1      = 8'h80;
   localparam logic [BYTE_W-1:0] BASE_LINE2      = 8'hC0;
   localparam logic [BYTE_W-1:0] BASE_LINE3_WIDE = 8'h94;
   localparam logic [BYTE_W-1:0] BASE_LINE4_WIDE = 8'hD4;
   localparam logic [BYTE_W-1:0] BASE_LINE3      = 8'h90;
   localparam logic [BYTE_W-1:0] BASE_LINE4      = 8'hD0;

   // controller commands
   localparam logic [BYTE_W-1:0] CMD_FUNC_2LINE = 8'b0010_1000;
   localparam logic [BYTE_W-1:0] CMD_FUNC_1LINE = 8'b0010_0000;
   localparam logic [BYTE_W-1:0] CMD_DISP_OFF   = 8'b0000_1000;
   localparam logic [BYTE_W-1:0] CMD_DISP_ON    = 8'b0000_1100;
   localparam logic [BYTE_W-1:0] CMD_ENTRY_MODE = 8'b0000_0110;
   localparam logic [BYTE_W-1:0] CMD_CLEAR      = 8'h01;

   localparam logic [NIBBLE_W-1:0] NIB_WAKE  = 4'h3;
   localparam logic [NIBBLE_W-1:0] NIB_4BIT  = 4'h2;

   localparam logic [TICK_W-1:0] WAIT_100US = 16'd100;
   localparam logic [TICK_W-1:0] WAIT_40US  = 16'd40;
   localparam logic [MS_W-1:0]   WAIT_5MS   = 8'd5;

   // register reset values
   localparam logic                RST_TWO_LINE  = 1'b1;
   localparam logic                RST_WIDE_ROWS = 1'b0;
   localparam logic [7:0]          RST_PULSE     = 8'd1;
   localparam logic [SETTLE_W-1:0] RST_SETTLE    = 10'd50;
   localparam logic [TICK_W-1:0]   RST_TICK_MS   = 16'd1000;
   localparam logic [MS_W-1:0]     RST_CLEAR_MS  = 8'd3;
   localparam logic [MS_W-1:0]     RST_POWER_MS  = 8'd15;

endpackage

[design/clni_if.sv]
// ----------------------------------------------------------------------------
// clni channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface clni_req_if;
   logic                                valid;
   logic                                ready;
   logic [clni_pkg::REQ_TYPE_W-1:0]     req_type;
   logic [clni_pkg::BYTE_W-1:0]         byte_value;
   logic [clni_pkg::LINE_W-1:0]         line_number;
   logic [clni_pkg::COLUMN_W-1:0]       column;

   modport source (output valid, req_type, byte_value, line_number, column,
                   input ready);
   modport sink   (input valid, req_type, byte_value, line_number, column,
                   output ready);
endinterface

interface clni_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                reg_select;
   logic                                enable_pin;
   logic [clni_pkg::NIBBLE_W-1:0]       data_nibble;
   logic                                watchdog_pin;
   logic                                busy_res;
   logic                                rejected;

   modport source (output valid, reg_select, enable_pin, data_nibble, watchdog_pin,
                   busy_res, rejected, input ready);
   modport sink   (input valid, reg_select, enable_pin, data_nibble, watchdog_pin,
                   busy_res, rejected, output ready);
endinterface

interface clni_csr_if;
   logic                                valid;
   logic                                ready;
   logic [clni_pkg::CSR_INDEX_W-1:0]    reg_index;
   logic [clni_pkg::CSR_DATA_W-1:0]     wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[design/char_lcd_nibble_interface.sv]
// The result of an accepted item is registered and offered on rsp_ch in the cycle
//   after the transfer; the pin sequencer advances in that same clock edge.
// Throughput: one item per cycle; a new item is taken while the previous result
//   waits in the output register, as long as that register frees this cycle.
// Reset (synchronous, active high): sequencer idle, pins low, registers at
//   their documented defaults, no result pending.
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// 4-bit write-only character LCD bus sequencer driven by microsecond ticks.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface (
   input  logic         clock,
   input  logic         reset,
   clni_req_if.sink     req_ch,
   clni_rsp_if.source   rsp_ch,
   clni_csr_if.sink     csr_ch
);
   import clni_pkg::*;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic                two_line_ff;
   logic                wide_rows_ff;
   logic [7:0]          pulse_ff;
   logic [SETTLE_W-1:0] settle_ff;
   logic [TICK_W-1:0]   tick_ms_ff;
   logic [MS_W-1:0]     clear_ms_ff;
   logic [MS_W-1:0]     power_ms_ff;

   // ------------------------------------------------------------------
   // sequencer state
   // ------------------------------------------------------------------
   phase_type           phase_ff, phase_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [MS_W-1:0]     ms_ff, ms_in;
   logic [BYTE_W-1:0]   held_ff, held_in;
   init_step_type       step_ff, step_in;
   logic                rs_ff, rs_in;
   logic                en_ff, en_in;
   logic [NIBBLE_W-1:0] nib_ff, nib_in;
   logic                wd_ff, wd_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_rs_ff, rsp_en_ff, rsp_wd_ff, rsp_busy_ff, rsp_rej_ff;
   logic [NIBBLE_W-1:0] rsp_nib_ff;

   logic                req_fire;
   logic                rej;

   // sequence start requests, applied after the phase decode
   logic                adv;
   init_step_type       adv_step;
   logic                sb;
   logic [BYTE_W-1:0]   sb_val;
   logic                sm;
   logic [MS_W-1:0]     sm_n;
   logic                ss;
   logic [NIBBLE_W-1:0] ss_nib;
   logic                su;
   logic [TICK_W-1:0]   su_n;

   // durations with zero read as one
   logic [TICK_W-1:0]   pulse_len;
   logic [TICK_W-1:0]   settle_len;
   logic [TICK_W-1:0]   ms_len;
   logic [BYTE_W-1:0]   cursor_base;

   // Accept a new item whenever the output register is empty or drains now.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign pulse_len  = (pulse_ff == 8'd0) ? TICK_W'(1) : TICK_W'(pulse_ff);
   assign settle_len = (settle_ff == '0) ? TICK_W'(1) : TICK_W'(settle_ff);
   assign ms_len     = (tick_ms_ff == '0) ? TICK_W'(1) : tick_ms_ff;

   // Pick the row base for a cursor move; lines outside one to four are dropped.
   always_comb begin
      unique case (req_ch.line_number)
         3'd1:    cursor_base = BASE_LINE1;
         3'd2:    cursor_base = BASE_LINE2;
         3'd3:    cursor_base = wide_rows_ff ? BASE_LINE3_WIDE : BASE_LINE3;
         3'd4:    cursor_base = wide_rows_ff ? BASE_LINE4_WIDE : BASE_LINE4;
         default: cursor_base = BASE_LINE1;
      endcase
   end

   // ------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         two_line_ff  <= RST_TWO_LINE;
         wide_rows_ff <= RST_WIDE_ROWS;
         pulse_ff     <= RST_PULSE;
         settle_ff    <= RST_SETTLE;
         tick_ms_ff   <= RST_TICK_MS;
         clear_ms_ff  <= RST_CLEAR_MS;
         power_ms_ff  <= RST_POWER_MS;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.reg_index)
            CSR_TWO_LINE:  two_line_ff  <= csr_ch.wr_data[0];
            CSR_WIDE_ROWS: wide_rows_ff <= csr_ch.wr_data[0];
            CSR_PULSE:     pulse_ff     <= csr_ch.wr_data[7:0];
            CSR_SETTLE:    settle_ff    <= csr_ch.wr_data[SETTLE_W-1:0];
            CSR_TICK_MS:   tick_ms_ff   <= csr_ch.wr_data[TICK_W-1:0];
            CSR_CLEAR_MS:  clear_ms_ff  <= csr_ch.wr_data[MS_W-1:0];
            CSR_POWER_MS:  power_ms_ff  <= csr_ch.wr_data[MS_W-1:0];
            default: ;  // index beyond the map: drop the write
         endcase
      end
   end

   // ------------------------------------------------------------------
   // next state: one pass per accepted item
   // ------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      ms_in    = ms_ff;
      held_in  = held_ff;
      step_in  = step_ff;
      rs_in    = rs_ff;
      en_in    = en_ff;
      nib_in   = nib_ff;
      wd_in    = wd_ff;
      rej      = 1'b0;
      adv      = 1'b0;
      adv_step = step_ff;
      sb       = 1'b0;
      sb_val   = '0;
      sm       = 1'b0;
      sm_n     = '0;
      ss       = 1'b0;
      ss_nib   = '0;
      su       = 1'b0;
      su_n     = '0;

      if (req_fire) begin
         case (req_ch.req_type) inside
            REQ_TICK: begin
               // Count down the current level; on expiry move to the next phase.
               if (phase_ff != PH_IDLE) begin
                  if (tick_ff > TICK_W'(1)) begin
                     tick_in = tick_ff - TICK_W'(1);
                  end else begin
                     tick_in = '0;
                     unique case (phase_ff)
                        PH_HI_EN: begin
                           en_in    = 1'b0;
                           nib_in   = held_ff[3:0];
                           phase_in = PH_GAP;
                           tick_in  = TICK_W'(1);
                        end
                        PH_GAP: begin
                           en_in    = 1'b1;
                           phase_in = PH_LO_EN;
                           tick_in  = pulse_len;
                        end
                        PH_LO_EN: begin
                           en_in    = 1'b0;
                           phase_in = PH_SETTLE;
                           tick_in  = settle_len;
                        end
                        PH_STROBE: begin
                           en_in = 1'b0;
                           adv   = 1'b1;
                        end
                        PH_WD_HI: begin
                           wd_in    = 1'b0;
                           phase_in = PH_WD_LO;
                           tick_in  = ms_len;
                        end
                        PH_WD_LO: begin
                           // Kick the watchdog again unless the last unit ended.
                           ms_in = ms_ff - MS_W'(1);
                           if (ms_ff != MS_W'(1)) begin
                              wd_in    = 1'b1;
                              phase_in = PH_WD_HI;
                              tick_in  = TICK_W'(1);
                           end else begin
                              adv = 1'b1;
                           end
                        end
                        default: adv = 1'b1;  // settle or fixed wait done
                     endcase
                  end
               end
            end
            REQ_CMD, REQ_CHAR, REQ_CURSOR, REQ_CLEAR, REQ_INIT: begin
               if (phase_ff != PH_IDLE) begin
                  rej = 1'b1;  // drop the request, keep the running sequence
               end else begin
                  case (req_ch.req_type)
                     REQ_CMD: begin
                        rs_in   = 1'b0;
                        step_in = STEP_NONE;
                        sb      = 1'b1;
                        sb_val  = req_ch.byte_value;
                     end
                     REQ_CHAR: begin
                        rs_in   = 1'b1;
                        step_in = STEP_NONE;
                        sb      = 1'b1;
                        sb_val  = req_ch.byte_value;
                     end
                     REQ_CURSOR: begin
                        if (req_ch.line_number >= 3'd1 && req_ch.line_number <= 3'd4) begin
                           rs_in   = 1'b0;
                           step_in = STEP_NONE;
                           sb      = 1'b1;
                           sb_val  = cursor_base - BYTE_W'(1)
                                     + BYTE_W'(req_ch.column);
                        end
                     end
                     REQ_CLEAR: begin
                        rs_in   = 1'b0;
                        step_in = STEP_CLEAR_TAIL;
                        sb      = 1'b1;
                        sb_val  = CMD_CLEAR;
                     end
                     default: begin  // init
                        rs_in    = 1'b0;
                        adv      = 1'b1;
                        adv_step = STEP_POWER_WAIT;
                     end
                  endcase
               end
            end
            default: ;  // unknown request code: no time passes
         endcase
      end

      // Step through the init and clear-tail sequence.
      if (adv) begin
         if (adv_step >= STEP_POWER_WAIT && adv_step <= STEP_DISP_ON) begin
            step_in = init_step_type'(adv_step + 4'd1);
         end else begin
            step_in = STEP_NONE;
         end
         unique case (adv_step)
            STEP_POWER_WAIT: begin sm = 1'b1; sm_n = power_ms_ff; end
            STEP_WAKE_1:     begin ss = 1'b1; ss_nib = NIB_WAKE; end
            STEP_WAIT_5MS_1: begin sm = 1'b1; sm_n = WAIT_5MS; end
            STEP_WAKE_2:     begin ss = 1'b1; ss_nib = nib_ff; end
            STEP_WAIT_100US: begin su = 1'b1; su_n = WAIT_100US; end
            STEP_WAKE_3:     begin ss = 1'b1; ss_nib = nib_ff; end
            STEP_WAIT_5MS_2: begin sm = 1'b1; sm_n = WAIT_5MS; end
            STEP_SET_4BIT:   begin ss = 1'b1; ss_nib = NIB_4BIT; end
            STEP_WAIT_40US:  begin su = 1'b1; su_n = WAIT_40US; end
            STEP_FUNC_SET: begin
               sb     = 1'b1;
               sb_val = two_line_ff ? CMD_FUNC_2LINE : CMD_FUNC_1LINE;
            end
            STEP_DISP_OFF:   begin sb = 1'b1; sb_val = CMD_DISP_OFF; end
            STEP_DISP_ON:    begin sb = 1'b1; sb_val = CMD_DISP_ON; end
            STEP_ENTRY_MODE: begin sb = 1'b1; sb_val = CMD_ENTRY_MODE; end
            STEP_CLEAR_TAIL: begin sm = 1'b1; sm_n = clear_ms_ff; end
            default: begin
               phase_in = PH_IDLE;
               en_in    = 1'b0;
               wd_in    = 1'b0;
               tick_in  = '0;
            end
         endcase
      end

      // Load the first level of whichever sequence starts.
      if (sb) begin
         held_in  = sb_val;
         nib_in   = sb_val[7:4];
         en_in    = 1'b1;
         phase_in = PH_HI_EN;
         tick_in  = pulse_len;
      end
      if (sm) begin
         ms_in    = (sm_n == '0) ? MS_W'(1) : sm_n;
         wd_in    = 1'b1;
         phase_in = PH_WD_HI;
         tick_in  = TICK_W'(1);
      end
      if (ss) begin
         nib_in   = ss_nib;
         en_in    = 1'b1;
         phase_in = PH_STROBE;
         tick_in  = pulse_len;
      end
      if (su) begin
         phase_in = PH_US_WAIT;
         tick_in  = su_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         ms_ff    <= '0;
         held_ff  <= '0;
         step_ff  <= STEP_NONE;
         rs_ff    <= 1'b0;
         en_ff    <= 1'b0;
         nib_ff   <= '0;
         wd_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         ms_ff    <= ms_in;
         held_ff  <= held_in;
         step_ff  <= step_in;
         rs_ff    <= rs_in;
         en_ff    <= en_in;
         nib_ff   <= nib_in;
         wd_ff    <= wd_in;
      end
   end

   // ------------------------------------------------------------------
   // output register: hold the result until the transfer completes
   // ------------------------------------------------------------------
   assign rsp_valid_in = req_fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_rs_ff   <= rs_in;
         rsp_en_ff   <= en_in;
         rsp_nib_ff  <= nib_in;
         rsp_wd_ff   <= wd_in;
         rsp_busy_ff <= (phase_in != PH_IDLE);
         rsp_rej_ff  <= rej;
      end
   end

   always_comb begin
      rsp_ch.valid        = rsp_valid_ff;
      rsp_ch.reg_select   = rsp_rs_ff;
      rsp_ch.enable_pin   = rsp_en_ff;
      rsp_ch.data_nibble  = rsp_nib_ff;
      rsp_ch.watchdog_pin = rsp_wd_ff;
      rsp_ch.busy_res     = rsp_busy_ff;
      rsp_ch.rejected     = rsp_rej_ff;
   end

endmodule
